// ===== src/dtd_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadline task dispatcher package
// Shared field widths, register codes and the cell control bundle.
// ----------------------------------------------------------------------------
package dtd_pkg;

  // Transaction field widths
  localparam int unsigned EXEC_W     = 10;
  localparam int unsigned DEADLINE_W = 16;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned MISS_W     = 2;

  typedef logic [EXEC_W-1:0]     exec_t;
  typedef logic [DEADLINE_W-1:0] deadline_t;
  typedef logic [19:0]           time_out_t;
  typedef logic [2:0]            proc_out_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [MISS_W-1:0]     miss_t;

  // Configuration port
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_COUNT_W = 4;

  typedef logic [CFG_COUNT_W-1:0] cfg_count_t;

  // Register index, taken from paddr[2]
  localparam logic REG_PROC_COUNT = 1'b0;

  localparam cfg_count_t PROC_COUNT_RESET = 4'd2;

  // Consecutive misses that switch to monotonic mode
  localparam miss_t MISS_LIMIT = 2'd2;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic clear;   // accepted transaction opens a new set
    logic admit;   // accepted transaction is assigned to the head
    logic sort;    // odd-even transposition step in progress
    logic phase;   // which neighbor pairs compare in this step
  } cell_ctrl_t;

endpackage

// ===== src/dtd_task_if.sv =====
// ----------------------------------------------------------------------------
// Task channel
// Valid/ready channel carrying one task per transaction.
// ----------------------------------------------------------------------------
interface dtd_task_if;
  logic                valid;
  logic                ready;
  dtd_pkg::exec_t      exec_time;
  dtd_pkg::deadline_t  deadline;
  logic                new_set;

  modport source (output valid, exec_time, deadline, new_set, input ready);
  modport sink   (input valid, exec_time, deadline, new_set, output ready);
endinterface

// ===== src/dtd_result_if.sv =====
// ----------------------------------------------------------------------------
// Dispatch result channel
// Valid/ready channel carrying one dispatch decision per transaction.
// ----------------------------------------------------------------------------
interface dtd_result_if;
  logic                valid;
  logic                ready;
  logic                scheduled;
  dtd_pkg::proc_out_t  chosen_processor;
  dtd_pkg::time_out_t  finish_time;
  logic                monotonic_mode;
  dtd_pkg::total_t     scheduled_total;
  dtd_pkg::time_out_t  processor_busy_total;

  modport source (output valid, scheduled, chosen_processor, finish_time, monotonic_mode,
                  scheduled_total, processor_busy_total, input ready);
  modport sink   (input valid, scheduled, chosen_processor, finish_time, monotonic_mode,
                  scheduled_total, processor_busy_total, output ready);
endinterface

// ===== src/dtd_cell.sv =====
// ----------------------------------------------------------------------------
// Dispatcher list cell
// Holds one processor entry of the list kept sorted by (inactive, free time,
// index). Inserts the re-queued head entry and runs transposition sort steps.
// ----------------------------------------------------------------------------
module dtd_cell #(
  parameter int unsigned TIME_BITS = 20,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned CNT_W     = 4,
  parameter int unsigned CELL_IDX  = 0,
  parameter bit          IS_LAST   = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dtd_pkg::cell_ctrl_t    ctrl_i,
  input  logic [CNT_W-1:0]       count_i,
  // entry re-queued from the head
  input  logic [IDX_W-1:0]       new_idx_i,
  input  logic [TIME_BITS-1:0]   new_free_i,
  input  logic [TIME_BITS-1:0]   new_busy_i,
  // left neighbor
  input  logic [IDX_W-1:0]       left_idx_i,
  input  logic [TIME_BITS-1:0]   left_free_i,
  input  logic [TIME_BITS-1:0]   left_busy_i,
  input  logic                   left_lt_i,
  // right neighbor
  input  logic [IDX_W-1:0]       right_idx_i,
  input  logic [TIME_BITS-1:0]   right_free_i,
  input  logic [TIME_BITS-1:0]   right_busy_i,
  input  logic                   right_lt_new_i,
  // current entry, with a new set already applied
  output logic [IDX_W-1:0]       idx_o,
  output logic [TIME_BITS-1:0]   free_o,
  output logic [TIME_BITS-1:0]   busy_o,
  output logic                   lt_new_o,
  output logic                   lt_right_o
);

  localparam int unsigned KEY_W = 1 + TIME_BITS + IDX_W;
  localparam logic [IDX_W-1:0] RST_IDX = IDX_W'(CELL_IDX);
  localparam logic CELL_ODD = 1'((CELL_IDX % 2));
  localparam bit   IS_HEAD  = (CELL_IDX == 0);

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [TIME_BITS-1:0] free_r, free_nxt;
  logic [TIME_BITS-1:0] busy_r, busy_nxt;
  logic [IDX_W-1:0]     eff_idx;
  logic [TIME_BITS-1:0] eff_free;
  logic [TIME_BITS-1:0] eff_busy;
  logic                 pair_left;
  logic                 pair_right;

  // Sort key: processors beyond the count go behind all active ones
  function automatic logic [KEY_W-1:0] key_of(input logic [IDX_W-1:0] idx,
                                              input logic [TIME_BITS-1:0] free,
                                              input logic [CNT_W-1:0] count);
    logic inactive;
    inactive = (CNT_W'(idx) >= count);
    return {inactive, free, idx};
  endfunction

  // Apply a new set to the view seen by the chain
  assign eff_idx  = ctrl_i.clear ? RST_IDX : idx_r;
  assign eff_free = ctrl_i.clear ? '0 : free_r;
  assign eff_busy = ctrl_i.clear ? '0 : busy_r;

  assign idx_o  = eff_idx;
  assign free_o = eff_free;
  assign busy_o = eff_busy;

  assign lt_new_o   = key_of(eff_idx, eff_free, count_i) <
                      key_of(new_idx_i, new_free_i, count_i);
  assign lt_right_o = key_of(eff_idx, eff_free, count_i) <
                      key_of(right_idx_i, right_free_i, count_i);

  // Role of this cell in the current transposition step
  assign pair_left  = !IS_LAST && (CELL_ODD == ctrl_i.phase);
  assign pair_right = !IS_HEAD && (CELL_ODD != ctrl_i.phase);

  // Pick the next entry: sort step, insertion, or hold
  always_comb begin
    idx_nxt  = eff_idx;
    free_nxt = eff_free;
    busy_nxt = eff_busy;
    if (ctrl_i.sort) begin
      if (pair_left && !lt_right_o) begin
        idx_nxt  = right_idx_i;
        free_nxt = right_free_i;
        busy_nxt = right_busy_i;
      end else if (pair_right && !left_lt_i) begin
        idx_nxt  = left_idx_i;
        free_nxt = left_free_i;
        busy_nxt = left_busy_i;
      end
    end else if (ctrl_i.admit) begin
      if (!IS_LAST && right_lt_new_i) begin
        idx_nxt  = right_idx_i;
        free_nxt = right_free_i;
        busy_nxt = right_busy_i;
      end else if (IS_HEAD || lt_new_o) begin
        idx_nxt  = new_idx_i;
        free_nxt = new_free_i;
        busy_nxt = new_busy_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= RST_IDX;
      free_r <= '0;
      busy_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      free_r <= free_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== src/deadline_task_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// Deadline task dispatcher
// Earliest-deadline-first list dispatcher over a chain of processor cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : tasks (exec_time, deadline, new_set), one transaction each,
//            already in deadline order. new_set clears all processor, miss
//            and mode state before that task is dispatched.
//   out_ch : one dispatch result per task, in task order.
//   cfg_*  : APB-style port; processor_count at byte address 0.
// Result valid rises in the cycle after task acceptance. One task is taken
// each cycle that in_ch.ready is high: processor entries sit in a row of cells
// sorted by free time, the head cell is the processor free soonest, and an
// assigned entry is reinserted in one step by local compares in every cell.
// The output register holds a result until it is taken; while out_ch
// stalls with a result pending, in_ch.ready drops.
// After reset all processors are free at time zero in deadline mode, with
// processor_count 2. After each processor_count write the cells run sort
// steps while the re-sort counter runs down, during which no task is accepted.
// ----------------------------------------------------------------------------
module deadline_task_dispatcher_unit #(
  parameter int unsigned MAX_PROCESSORS = 8,
  parameter int unsigned TIME_BITS      = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dtd_task_if.sink                          in_ch,
  dtd_result_if.source                      out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dtd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dtd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dtd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned IDX_W  = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PROCESSORS + 1);
  localparam int unsigned CCMP_W = (CNT_W > dtd_pkg::CFG_COUNT_W) ? CNT_W
                                                                  : dtd_pkg::CFG_COUNT_W;
  localparam int unsigned SUM_W  = ((TIME_BITS > dtd_pkg::EXEC_W) ? TIME_BITS
                                                                  : dtd_pkg::EXEC_W) + 1;
  localparam int unsigned DCMP_W = (TIME_BITS > dtd_pkg::DEADLINE_W) ? TIME_BITS
                                                                     : dtd_pkg::DEADLINE_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Configuration and control state
  dtd_pkg::cfg_count_t   proc_count_r;
  logic [CNT_W-1:0]      sort_cnt_r, sort_cnt_nxt;
  dtd_pkg::miss_t        miss_r, miss_nxt;
  logic                  mode_r, mode_nxt;
  dtd_pkg::total_t       assigned_r, assigned_nxt;

  // Output register
  logic                  out_valid_r;
  logic                  res_sched_r;
  dtd_pkg::proc_out_t    res_proc_r;
  dtd_pkg::time_out_t    res_finish_r;
  logic                  res_mode_r;
  dtd_pkg::total_t       res_total_r;
  dtd_pkg::time_out_t    res_busy_r;

  logic                  cfg_wr;
  logic                  sorting;
  logic                  in_fire;
  logic [CNT_W-1:0]      count_eff;
  dtd_pkg::cell_ctrl_t   cell_ctrl;

  // Cell row
  logic [IDX_W-1:0]      c_idx      [MAX_PROCESSORS];
  logic [TIME_BITS-1:0]  c_free     [MAX_PROCESSORS];
  logic [TIME_BITS-1:0]  c_busy     [MAX_PROCESSORS];
  logic                  c_lt_new   [MAX_PROCESSORS];
  logic                  c_lt_right [MAX_PROCESSORS];
  logic [IDX_W-1:0]      l_idx      [MAX_PROCESSORS];
  logic [TIME_BITS-1:0]  l_free     [MAX_PROCESSORS];
  logic [TIME_BITS-1:0]  l_busy     [MAX_PROCESSORS];
  logic                  l_lt       [MAX_PROCESSORS];
  logic [IDX_W-1:0]      r_idx      [MAX_PROCESSORS];
  logic [TIME_BITS-1:0]  r_free     [MAX_PROCESSORS];
  logic [TIME_BITS-1:0]  r_busy     [MAX_PROCESSORS];
  logic                  r_lt_new   [MAX_PROCESSORS];

  // Head decision
  logic                  mode_eff;
  dtd_pkg::miss_t        miss_eff;
  dtd_pkg::total_t       assigned_eff;
  logic                  admit;
  logic [SUM_W-1:0]      free_sum;
  logic [SUM_W-1:0]      busy_sum;
  logic [TIME_BITS-1:0]  finish;
  logic [TIME_BITS-1:0]  busy_new;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == dtd_pkg::REG_PROC_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == dtd_pkg::REG_PROC_COUNT)
                      ? dtd_pkg::CFG_DATA_W'(proc_count_r) : '0;

  // Clamp the processor count into 1..MAX_PROCESSORS
  always_comb begin
    priority if (proc_count_r == '0) begin
      count_eff = CNT_W'(1);
    end else if (CCMP_W'(proc_count_r) > CCMP_W'(MAX_PROCESSORS)) begin
      count_eff = CNT_W'(MAX_PROCESSORS);
    end else begin
      count_eff = CNT_W'(proc_count_r);
    end
  end

  // Re-sort the row after a count change; hold off tasks meanwhile
  assign sorting      = (sort_cnt_r != '0);
  assign sort_cnt_nxt = cfg_wr ? CNT_W'(MAX_PROCESSORS)
                      : (sorting ? sort_cnt_r - CNT_W'(1) : sort_cnt_r);

  assign in_ch.ready = !sorting && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // State seen by this task after an optional new set
  assign mode_eff     = in_ch.new_set ? 1'b0 : mode_r;
  assign miss_eff     = in_ch.new_set ? '0 : miss_r;
  assign assigned_eff = in_ch.new_set ? '0 : assigned_r;

  // Admission test and saturating updates at the head
  assign admit    = mode_eff || (DCMP_W'(c_free[0]) <= DCMP_W'(in_ch.deadline));
  assign free_sum = SUM_W'(c_free[0]) + SUM_W'(in_ch.exec_time);
  assign busy_sum = SUM_W'(c_busy[0]) + SUM_W'(in_ch.exec_time);
  assign finish   = (free_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(free_sum);
  assign busy_new = (busy_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(busy_sum);

  assign cell_ctrl.clear = in_fire && in_ch.new_set;
  assign cell_ctrl.admit = in_fire && admit;
  assign cell_ctrl.sort  = sorting;
  assign cell_ctrl.phase = sort_cnt_r[0];

  // Miss counter, mode flag and assignment count
  always_comb begin
    miss_nxt     = miss_r;
    mode_nxt     = mode_r;
    assigned_nxt = assigned_r;
    if (in_fire) begin
      mode_nxt     = mode_eff;
      assigned_nxt = assigned_eff;
      if (admit) begin
        miss_nxt = '0;
        if (assigned_eff != '1) begin
          assigned_nxt = assigned_eff + dtd_pkg::TOTAL_W'(1);
        end
      end else if (dtd_pkg::miss_t'(miss_eff + 2'd1) >= dtd_pkg::MISS_LIMIT) begin
        miss_nxt = '0;
        mode_nxt = 1'b1;
      end else begin
        miss_nxt = dtd_pkg::miss_t'(miss_eff + 2'd1);
      end
    end
  end

  // Wire neighbors and build the row
  for (genvar i = 0; i < MAX_PROCESSORS; i++) begin : g_cell
    if (i == 0) begin : g_no_left
      assign l_idx[i]  = '0;
      assign l_free[i] = '0;
      assign l_busy[i] = '0;
      assign l_lt[i]   = 1'b0;
    end else begin : g_left
      assign l_idx[i]  = c_idx[i-1];
      assign l_free[i] = c_free[i-1];
      assign l_busy[i] = c_busy[i-1];
      assign l_lt[i]   = c_lt_right[i-1];
    end
    if (i == MAX_PROCESSORS - 1) begin : g_no_right
      assign r_idx[i]    = '0;
      assign r_free[i]   = '0;
      assign r_busy[i]   = '0;
      assign r_lt_new[i] = 1'b0;
    end else begin : g_right
      assign r_idx[i]    = c_idx[i+1];
      assign r_free[i]   = c_free[i+1];
      assign r_busy[i]   = c_busy[i+1];
      assign r_lt_new[i] = c_lt_new[i+1];
    end

    dtd_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .CELL_IDX  (i),
      .IS_LAST   (i == MAX_PROCESSORS - 1)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl_i         (cell_ctrl),
      .count_i        (count_eff),
      .new_idx_i      (c_idx[0]),
      .new_free_i     (finish),
      .new_busy_i     (busy_new),
      .left_idx_i     (l_idx[i]),
      .left_free_i    (l_free[i]),
      .left_busy_i    (l_busy[i]),
      .left_lt_i      (l_lt[i]),
      .right_idx_i    (r_idx[i]),
      .right_free_i   (r_free[i]),
      .right_busy_i   (r_busy[i]),
      .right_lt_new_i (r_lt_new[i]),
      .idx_o          (c_idx[i]),
      .free_o         (c_free[i]),
      .busy_o         (c_busy[i]),
      .lt_new_o       (c_lt_new[i]),
      .lt_right_o     (c_lt_right[i])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r <= dtd_pkg::PROC_COUNT_RESET;
      sort_cnt_r   <= '0;
      miss_r       <= '0;
      mode_r       <= 1'b0;
      assigned_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        proc_count_r <= cfg_pwdata[dtd_pkg::CFG_COUNT_W-1:0];
      end
      sort_cnt_r  <= sort_cnt_nxt;
      miss_r      <= miss_nxt;
      mode_r      <= mode_nxt;
      assigned_r  <= assigned_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result on each accepted task
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_sched_r  <= admit;
      res_proc_r   <= dtd_pkg::proc_out_t'(c_idx[0]);
      res_finish_r <= dtd_pkg::time_out_t'(admit ? finish : '0);
      res_mode_r   <= mode_nxt;
      res_total_r  <= assigned_nxt;
      res_busy_r   <= dtd_pkg::time_out_t'(admit ? busy_new : c_busy[0]);
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.scheduled            = res_sched_r;
  assign out_ch.chosen_processor     = res_proc_r;
  assign out_ch.finish_time          = res_finish_r;
  assign out_ch.monotonic_mode       = res_mode_r;
  assign out_ch.scheduled_total      = res_total_r;
  assign out_ch.processor_busy_total = res_busy_r;

  // Checks
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_ch.valid)
    else $error("accepted task produced no result");

  a_no_task_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
    sorting |-> !in_ch.ready)
    else $error("task accepted during re-sort");

  a_head_active: assert property (@(posedge clk) disable iff (!rst_n)
    !sorting |-> (CNT_W'(c_idx[0]) < count_eff))
    else $error("head cell holds an inactive processor");

  a_new_set_total: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.new_set) |=> (out_ch.scheduled_total <= dtd_pkg::TOTAL_W'(1)))
    else $error("new set did not clear the assignment count");

  a_drop_no_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !admit) |=> (out_ch.finish_time == '0 && !out_ch.scheduled))
    else $error("dropped task reported a finish time");

endmodule
